@@ hdl/ircr_pkg.sv @@
// ----------------------------------------------------------------------------
// ircr_pkg: shared types and constants of the IR code record and replay block
// Command and mode codes, the item, result and configuration words, the
// control state and the write request that goes to the code store.
// ----------------------------------------------------------------------------
`default_nettype none

package ircr_pkg;

	// Field widths fixed by the interface.
	localparam int CMD_W      = 3;
	localparam int POS_W      = 9;
	localparam int EXT_W      = POS_W + 1;
	localparam int BYTE_W     = 8;
	localparam int TICK_W     = 16;
	localparam int OVF_W      = 8;
	localparam int STATUS_W   = 2;
	localparam int REG_IDX_W  = 4;
	localparam int REG_DATA_W = 9;

	// The store is split into byte-wide banks so that the three bytes of one
	// entry can all be written at once.
	localparam int BANK_W = 2;
	localparam int BANKS  = 1 << BANK_W;
	localparam int LANES  = 3;

	// Register indices of the configuration port.
	localparam logic [REG_IDX_W-1:0] CFG_BYTE_LIMIT = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] CFG_SILENCE    = REG_IDX_W'(1);

	// Reset values and fixed numbers.
	localparam logic [POS_W-1:0]  BYTE_LIMIT_RST = 9'd507;
	localparam logic [OVF_W-1:0]  SILENCE_RST    = 8'd76;
	localparam logic [BYTE_W-1:0] END_MARK_BYTE  = 8'hFF;
	localparam logic [TICK_W-1:0] TICK_MAX       = 16'hFFFF;
	localparam logic [POS_W-1:0]  POS_MAX        = 9'd511;
	localparam logic [POS_W-1:0]  POS_STEP       = 9'd3;
	localparam logic [POS_W-1:0]  POS_SEND_START = 9'd3;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 3'd0,
		CMD_EDGE   = 3'd1,
		CMD_RECORD = 3'd2,
		CMD_SEND   = 3'd3,
		CMD_STOP   = 3'd4,
		CMD_READ   = 3'd5,
		CMD_WRITE  = 3'd6
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		MODE_IDLE   = 2'd0,
		MODE_SEND   = 2'd1,
		MODE_RECORD = 2'd2,
		MODE_AVAIL  = 2'd3
	} mode_t;

	// One input word.
	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [POS_W-1:0]  address;
		logic [BYTE_W-1:0] write_data;
	} item_t;

	// One result word.
	typedef struct packed {
		logic [STATUS_W-1:0] ir_status;
		logic                carrier_gate;
		logic                status_report;
		logic [BYTE_W-1:0]   read_data;
	} result_t;

	// One configuration write.
	typedef struct packed {
		logic [REG_IDX_W-1:0]  reg_index;
		logic [REG_DATA_W-1:0] reg_data;
	} cfg_word_t;

	typedef struct packed {
		logic [POS_W-1:0] byte_limit;
		logic [OVF_W-1:0] silence;
	} cfg_regs_t;

	typedef struct packed {
		mode_t             mode;
		logic [TICK_W-1:0] tick;
		logic [OVF_W-1:0]  ovf;
		logic [POS_W-1:0]  pos;
		logic              carrier;
	} state_t;

	localparam state_t STATE_IDLE = '{
		mode: MODE_IDLE, tick: '0, ovf: '0, pos: '0, carrier: 1'b0
	};

	// Up to three byte writes into the code store, at unwrapped addresses.
	typedef struct packed {
		logic [LANES-1:0]             en;
		logic [LANES-1:0][EXT_W-1:0]  addr;
		logic [LANES-1:0][BYTE_W-1:0] data;
	} store_wr_t;

endpackage

`default_nettype wire

@@ hdl/ircr_stream_if.sv @@
// ----------------------------------------------------------------------------
// ircr_stream_if: valid/ready channel
// Carries one payload word per handshake; a word moves on a rising edge at
// which valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface ircr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/ircr_ram.sv @@
// ----------------------------------------------------------------------------
// ircr_ram: generic single-write, dual-read RAM
// One write port and two read ports, each read registered under its own
// enable. A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module ircr_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 128,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re_a,
	input  wire logic [AW-1:0]    raddr_a,
	output      logic [WIDTH-1:0] rdata_a,
	input  wire logic             re_b,
	input  wire logic [AW-1:0]    raddr_b,
	output      logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and both registered read ports.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

@@ hdl/ircr_store.sv @@
// ----------------------------------------------------------------------------
// ircr_store: banked code store with write forwarding
// Four byte-wide banks hold the code buffer. Port A serves host reads, port
// B fetches the duration of the entry at the playback position. Writes of
// the latest item are forwarded over the stale RAM data, and bytes 1 and 2
// are shadowed in registers for the start of playback.
// ----------------------------------------------------------------------------
`default_nettype none

module ircr_store
	import ircr_pkg::*;
#(
	parameter int BUFFER_BYTES = 512
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_fire,
	input  wire store_wr_t           wr,
	input  wire logic                host_re,
	input  wire logic [POS_W-1:0]    host_addr,
	input  wire logic                dur_re,
	input  wire logic [POS_W-1:0]    dur_pos,
	output      logic [BYTE_W-1:0]   host_byte,
	output      logic [TICK_W-1:0]   dur_at_pos,
	output      logic [TICK_W-1:0]   dur_start
);

	localparam int AW     = $clog2(BUFFER_BYTES);
	localparam int ROW_W  = AW - BANK_W;
	localparam int DEPTH  = BUFFER_BYTES / BANKS;

	// Reduction modulo the buffer size by a scaled reciprocal; the quotient
	// is exact for every address below 1024.
	localparam int SHIFT   = 24;
	localparam int RECIP_W = 21;
	localparam int PROD_W  = EXT_W + RECIP_W;
	localparam int QUOT_W  = PROD_W - SHIFT;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << SHIFT) / BUFFER_BYTES + 1);

	function automatic logic [AW-1:0] wrap_addr(input logic [EXT_W-1:0] a);
		logic [PROD_W-1:0] prod;
		logic [QUOT_W-1:0] quot;
		logic [EXT_W-1:0]  rem;
		prod = PROD_W'(a) * PROD_W'(RECIP);
		quot = prod[PROD_W-1:SHIFT];
		rem  = a - EXT_W'(quot * BUFFER_BYTES);
		return AW'(rem);
	endfunction

	logic [LANES-1:0][AW-1:0]     ww;
	logic [BANKS-1:0]             bank_we;
	logic [BANKS-1:0][ROW_W-1:0]  bank_waddr;
	logic [BANKS-1:0][BYTE_W-1:0] bank_wdata;
	logic [BANKS-1:0][ROW_W-1:0]  bank_raddr_b;
	logic [BANKS-1:0][BYTE_W-1:0] rd_a;
	logic [BANKS-1:0][BYTE_W-1:0] rd_b;
	logic [AW-1:0]                host_w;
	logic [AW-1:0]                d1_w;
	logic [AW-1:0]                d2_w;
	logic [AW-1:0]                host_q;
	logic [AW-1:0]                d1_q;
	logic [AW-1:0]                d2_q;
	logic [LANES-1:0]             fw_en_q;
	logic [LANES-1:0][AW-1:0]     fw_addr_q;
	logic [LANES-1:0][BYTE_W-1:0] fw_data_q;
	logic [BYTE_W-1:0]            shadow1_q;
	logic [BYTE_W-1:0]            shadow2_q;

	// Wrapped addresses of the write lanes and the two read streams.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			ww[l] = wrap_addr(wr.addr[l]);
		end
		host_w = wrap_addr(EXT_W'(host_addr));
		d1_w   = wrap_addr(EXT_W'(dur_pos) + EXT_W'(1));
		d2_w   = wrap_addr(EXT_W'(dur_pos) + EXT_W'(2));
	end

	// Steer each write lane to its bank; the lanes of one entry fall in
	// different banks.
	always_comb begin
		bank_we    = '0;
		bank_waddr = '0;
		bank_wdata = '0;
		for (int l = 0; l < LANES; l++) begin
			if (wr_fire && wr.en[l]) begin
				bank_we[ww[l][BANK_W-1:0]]    = 1'b1;
				bank_waddr[ww[l][BANK_W-1:0]] = ww[l][AW-1:BANK_W];
				bank_wdata[ww[l][BANK_W-1:0]] = wr.data[l];
			end
		end
	end

	// Duration fetch: each bank reads whichever of the two bytes it holds.
	always_comb begin
		for (int b = 0; b < BANKS; b++) begin
			if (d1_w[BANK_W-1:0] == BANK_W'(b)) begin
				bank_raddr_b[b] = d1_w[AW-1:BANK_W];
			end else begin
				bank_raddr_b[b] = d2_w[AW-1:BANK_W];
			end
		end
	end

	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		ircr_ram #(
			.WIDTH (BYTE_W),
			.DEPTH (DEPTH)
		) u_bank (
			.clk     (clk),
			.we      (bank_we[b]),
			.waddr   (bank_waddr[b]),
			.wdata   (bank_wdata[b]),
			.re_a    (host_re),
			.raddr_a (host_w[AW-1:BANK_W]),
			.rdata_a (rd_a[b]),
			.re_b    (dur_re),
			.raddr_b (bank_raddr_b[b]),
			.rdata_b (rd_b[b])
		);
	end

	// Addresses of the outstanding reads, held with the RAM output.
	always_ff @(posedge clk) begin
		if (host_re) begin
			host_q <= host_w;
		end
		if (dur_re) begin
			d1_q <= d1_w;
			d2_q <= d2_w;
		end
	end

	// Writes of the most recent item, which the RAM reads taken at the same
	// edge do not see yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_en_q <= '0;
		end else if (wr_fire) begin
			fw_en_q <= wr.en;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			for (int l = 0; l < LANES; l++) begin
				fw_addr_q[l] <= ww[l];
				fw_data_q[l] <= wr.data[l];
			end
		end
	end

	// Shadow copies of bytes 1 and 2, the duration of the first entry.
	always_ff @(posedge clk) begin
		if (wr_fire) begin
			for (int l = 0; l < LANES; l++) begin
				if (wr.en[l] && ww[l] == AW'(1)) begin
					shadow1_q <= wr.data[l];
				end
				if (wr.en[l] && ww[l] == AW'(2)) begin
					shadow2_q <= wr.data[l];
				end
			end
		end
	end

	function automatic logic [BYTE_W-1:0] forward(
		input logic [AW-1:0]     a,
		input logic [BYTE_W-1:0] mem_byte
	);
		logic [BYTE_W-1:0] v;
		v = mem_byte;
		for (int l = 0; l < LANES; l++) begin
			if (fw_en_q[l] && fw_addr_q[l] == a) begin
				v = fw_data_q[l];
			end
		end
		return v;
	endfunction

	// Read data with the latest writes merged in.
	always_comb begin
		host_byte  = forward(host_q, rd_a[host_q[BANK_W-1:0]]);
		dur_at_pos = {forward(d1_q, rd_b[d1_q[BANK_W-1:0]]),
		              forward(d2_q, rd_b[d2_q[BANK_W-1:0]])};
		dur_start  = {shadow1_q, shadow2_q};
	end

endmodule

`default_nettype wire

@@ hdl/ircr_ctrl.sv @@
// ----------------------------------------------------------------------------
// ircr_ctrl: record and playback control
// Works out, for the item in the input register, the next control state,
// the result word and the bytes to write into the code store.
// ----------------------------------------------------------------------------
`default_nettype none

module ircr_ctrl
	import ircr_pkg::*;
(
	input  wire item_t             item,
	input  wire state_t            st,
	input  wire cfg_regs_t         regs,
	input  wire logic [BYTE_W-1:0] host_byte,
	input  wire logic [TICK_W-1:0] dur_at_pos,
	input  wire logic [TICK_W-1:0] dur_start,
	output      state_t            nxt,
	output      result_t           res,
	output      store_wr_t         wr
);

	cmd_t              cmd;
	logic              timer_run;
	logic [TICK_W-1:0] tick_inc;
	logic              wrapped;
	logic [TICK_W-1:0] reload;
	logic              at_limit;
	logic              send_end;
	logic              silence_hit;
	logic [EXT_W-1:0]  pos_sum;
	logic [POS_W-1:0]  pos_adv;

	// Shared conditions.
	always_comb begin
		cmd         = cmd_t'(item.command);
		timer_run   = (st.mode == MODE_SEND) || (st.mode == MODE_RECORD);
		tick_inc    = st.tick + TICK_W'(1);
		wrapped     = (tick_inc == '0);
		reload      = TICK_MAX - dur_at_pos;
		at_limit    = (st.pos >= regs.byte_limit);
		send_end    = (reload == '0) || at_limit;
		silence_hit = (st.ovf == regs.silence);
		pos_sum     = EXT_W'(st.pos) + EXT_W'(POS_STEP);
		pos_adv     = (pos_sum > EXT_W'(POS_MAX)) ? POS_MAX : pos_sum[POS_W-1:0];
	end

	// Next state.
	always_comb begin
		nxt = st;
		unique case (cmd)
			CMD_TICK: begin
				if (timer_run) begin
					if (!wrapped) begin
						nxt.tick = tick_inc;
					end else if (st.mode == MODE_SEND) begin
						// Timer overflow while sending: next mark or space, or idle at the end.
						if (send_end) begin
							nxt = STATE_IDLE;
						end else begin
							nxt.carrier = ~st.carrier;
							nxt.tick    = reload;
							nxt.pos     = pos_adv;
						end
					end else if (silence_hit) begin
						nxt = STATE_IDLE;
					end else begin
						nxt.ovf  = st.ovf + OVF_W'(1);
						nxt.tick = '0;
					end
				end
			end
			CMD_EDGE: begin
				if (st.mode == MODE_RECORD) begin
					nxt.tick = '0;
					if (at_limit) begin
						nxt.mode = MODE_AVAIL;
					end else begin
						nxt.pos = pos_adv;
						nxt.ovf = '0;
					end
				end
			end
			CMD_RECORD: begin
				nxt      = STATE_IDLE;
				nxt.mode = MODE_RECORD;
			end
			CMD_SEND: begin
				nxt.mode    = MODE_SEND;
				nxt.tick    = TICK_MAX - dur_start;
				nxt.pos     = POS_SEND_START;
				nxt.carrier = 1'b1;
			end
			CMD_STOP: begin
				nxt = STATE_IDLE;
			end
			default: begin
				// Host reads, host writes and the unused code leave the state.
			end
		endcase
	end

	// Result word and store writes.
	always_comb begin
		res.ir_status     = nxt.mode;
		res.carrier_gate  = nxt.carrier;
		res.status_report = 1'b0;
		res.read_data     = '0;
		wr                = '0;
		unique case (cmd)
			CMD_TICK: begin
				res.status_report = timer_run && wrapped && (st.mode == MODE_RECORD) &&
				                    silence_hit;
			end
			CMD_EDGE: begin
				if (st.mode == MODE_RECORD) begin
					res.status_report = at_limit;
					wr.en      = '1;
					wr.addr[0] = EXT_W'(st.pos);
					wr.addr[1] = EXT_W'(st.pos) + EXT_W'(1);
					wr.addr[2] = EXT_W'(st.pos) + EXT_W'(2);
					if (at_limit) begin
						// End mark.
						wr.data = {LANES{END_MARK_BYTE}};
					end else begin
						wr.data[0] = st.ovf;
						wr.data[1] = st.tick[TICK_W-1:BYTE_W];
						wr.data[2] = st.tick[BYTE_W-1:0];
					end
				end
			end
			CMD_READ: begin
				res.read_data = host_byte;
			end
			CMD_WRITE: begin
				wr.en[0]   = 1'b1;
				wr.addr[0] = EXT_W'(item.address);
				wr.data[0] = item.write_data;
			end
			default: begin
				// No store access and no report.
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/ir_code_record_replay.sv @@
// ----------------------------------------------------------------------------
// ir_code_record_replay: infrared code learning and playback
// Records receiver edge timings into a code buffer and plays them back as a
// carrier gate, with host byte access to the buffer.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while its results are taken and
// gives one result per item. An accepted item waits in the input register,
// where the code store's registered read returns its data, and its result
// is then registered in the result register; the rate is bounded by the
// single pass from input register to result register. The code store is
// four byte-wide RAM banks, so BUFFER_BYTES must be a multiple of four.
// Store contents are undefined until written; there is no clearing pass
// after reset. Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_code_record_replay
	import ircr_pkg::*;
#(
	parameter int BUFFER_BYTES = 512
) (
	input wire logic   clk,
	input wire logic   arst_n,
	ircr_stream_if.sink   items,
	ircr_stream_if.source results,
	ircr_stream_if.sink   cfg
);

	item_t             item_s1;
	logic              valid_s1;
	result_t           res_s2;
	logic              valid_s2;
	state_t            state_q;
	cfg_regs_t         regs_q;
	state_t            state_nxt;
	result_t           res_nxt;
	store_wr_t         wr_req;
	logic              fire;
	logic              accept;
	logic [BYTE_W-1:0] host_byte;
	logic [TICK_W-1:0] dur_at_pos;
	logic [TICK_W-1:0] dur_start;

	// Handshake: the input register moves on whenever the result register
	// is empty or being emptied.
	assign fire          = valid_s1 && (!valid_s2 || results.ready);
	assign items.ready   = !valid_s1 || fire;
	assign accept        = items.valid && items.ready;
	assign results.valid = valid_s2;
	assign results.payload = res_s2;
	assign cfg.ready     = 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= items.payload;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_nxt;
		end
	end

	// Control state, updated as each item completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_IDLE;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.byte_limit <= BYTE_LIMIT_RST;
			regs_q.silence    <= SILENCE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.payload.reg_index)
				CFG_BYTE_LIMIT: regs_q.byte_limit <= cfg.payload.reg_data[POS_W-1:0];
				CFG_SILENCE:    regs_q.silence    <= cfg.payload.reg_data[OVF_W-1:0];
				default: begin
					// Writes to unknown registers are dropped.
				end
			endcase
		end
	end

	ircr_ctrl u_ctrl (
		.item       (item_s1),
		.st         (state_q),
		.regs       (regs_q),
		.host_byte  (host_byte),
		.dur_at_pos (dur_at_pos),
		.dur_start  (dur_start),
		.nxt        (state_nxt),
		.res        (res_nxt),
		.wr         (wr_req)
	);

	// The duration fetch follows the position each completed item leaves.
	ircr_store #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_fire    (fire),
		.wr         (wr_req),
		.host_re    (accept),
		.host_addr  (items.payload.address),
		.dur_re     (fire),
		.dur_pos    (state_nxt.pos),
		.host_byte  (host_byte),
		.dur_at_pos (dur_at_pos),
		.dur_start  (dur_start)
	);

	// The carrier can only be gated on during playback.
	a_carrier_in_send: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.carrier |-> state_q.mode == MODE_SEND)
		else $error("carrier gate on outside playback");

	// The timer is stopped whenever neither recording nor sending.
	a_timer_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode == MODE_IDLE || state_q.mode == MODE_AVAIL) |-> state_q.tick == '0)
		else $error("timer running while idle or holding a record");

	// Idle always means a cleared position and overflow count.
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_IDLE |-> (state_q.pos == '0 && state_q.ovf == '0))
		else $error("idle with stale position or overflow count");

	// A completed item always leaves a result waiting in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("completed item produced no result");

endmodule

`default_nettype wire
